// ===== design/tpct_pkg.sv =====
// shared types, constants and helpers for the routing-tree parent and child table
// no dependencies
package tpct_pkg;

    localparam int CHILD_SLOTS = 10;
    localparam int IDX_W = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1;
    localparam int ADDR_W = 16;
    localparam int AGE_W = 8;
    localparam int RANK_W = 8;

    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 8'd45;
    localparam logic [RANK_W-1:0] NO_ROUTE = 8'd255;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_ADVERT = 2'd1,
        FUNC_KEEP   = 2'd2,
        FUNC_BEACON = 2'd3
    } func_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [AGE_W-1:0]  age;
    } slot_t;

    function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] age,
                                                input logic [AGE_W-1:0] timeout);
        return (age < timeout) ? age + AGE_W'(1) : age;
    endfunction

    function automatic logic expired(input logic [AGE_W-1:0] age,
                                     input logic [AGE_W-1:0] timeout);
        return age >= timeout;
    endfunction

endpackage

// ===== design/tree_parent_and_child_table.sv =====
// top level of the routing-tree parent and child table
// depends on tpct_pkg and tpct_cell
//
// Each input word takes one result word. The child slots sit in a ring of
// CHILD_SLOTS cells that rotates one place per cycle, in the scan and apply
// states only, past a single head port. A rank advert does not rotate the ring,
// a tick or a beacon takes one rotation, and a child keepalive needs one
// rotation to find the slot and one to write it. A new word is taken while
// the previous result still waits at the output register. The timeout
// register may only be written while idle.
module tree_parent_and_child_table
    import tpct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [AGE_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [ADDR_W-1:0] from_addr,
    input  logic [RANK_W-1:0] adv_rank,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              send_beacon,
    output logic [RANK_W-1:0] rank_out,
    output logic [ADDR_W-1:0] parent_out,
    output logic              parent_valid,
    output logic              parent_changed,
    output logic              child_dropped
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    func_t func_reg, func_next;
    logic [ADDR_W-1:0] from_reg, from_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic match_found_reg, match_found_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic empty_found_reg, empty_found_next;
    logic [IDX_W-1:0] empty_idx_reg, empty_idx_next;

    logic [AGE_W-1:0] timeout_reg;
    logic [ADDR_W-1:0] parent_address_reg, parent_address_next;
    logic parent_held_reg, parent_held_next;
    logic [RANK_W-1:0] own_rank_reg, own_rank_next;
    logic [AGE_W-1:0] parent_age_reg, parent_age_next;

    logic res_beacon_reg, res_beacon_next;
    logic [RANK_W-1:0] res_rank_reg, res_rank_next;
    logic [ADDR_W-1:0] res_parent_reg, res_parent_next;
    logic res_pvalid_reg, res_pvalid_next;
    logic res_changed_reg, res_changed_next;

    logic out_valid_reg, out_valid_next;
    logic send_beacon_reg, send_beacon_next;
    logic [RANK_W-1:0] rank_out_reg, rank_out_next;
    logic [ADDR_W-1:0] parent_out_reg, parent_out_next;
    logic parent_valid_reg, parent_valid_next;
    logic parent_changed_reg, parent_changed_next;
    logic child_dropped_reg, child_dropped_next;

    slot_t ring_q [CHILD_SLOTS];
    slot_t ring_d [CHILD_SLOTS];
    slot_t head, tail;
    logic shift_en;
    logic [RANK_W:0] adv_sum;
    logic [IDX_W-1:0] target_idx;
    logic last_slot;

    // slot ring: cell i takes from cell i+1, the last cell takes the head result
    for (genvar i = 0; i < CHILD_SLOTS; i++)
    begin : g_ring
        if (i == CHILD_SLOTS - 1)
        begin : g_last
            assign ring_d[i] = tail;
        end
        else
        begin : g_mid
            assign ring_d[i] = ring_q[i+1];
        end
        tpct_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .slot_in  (ring_d[i]),
            .slot_out (ring_q[i])
        );
    end

    assign head = ring_q[0];
    assign shift_en = (state_reg == S_SCAN) || (state_reg == S_APPLY);
    assign last_slot = (cnt_reg == IDX_W'(CHILD_SLOTS - 1));
    assign target_idx = match_found_reg ? match_idx_reg : empty_idx_reg;
    assign adv_sum = {1'b0, adv_rank} + (RANK_W+1)'(1);

    // head slot update
    always_comb
    begin
        tail = head;
        if (state_reg == S_SCAN)
        begin
            case (func_reg)
                FUNC_TICK:   tail.age = age_up(head.age, timeout_reg);
                FUNC_BEACON:
                begin
                    if (expired(head.age, timeout_reg))
                    begin
                        tail.addr = '0;
                    end
                end
                default:     tail = head;
            endcase
        end
        else if (state_reg == S_APPLY)
        begin
            if ((match_found_reg || empty_found_reg) && cnt_reg == target_idx)
            begin
                tail.addr = from_reg;
                tail.age  = '0;
            end
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        func_next           = func_reg;
        from_next           = from_reg;
        cnt_next            = cnt_reg;
        match_found_next    = match_found_reg;
        match_idx_next      = match_idx_reg;
        empty_found_next    = empty_found_reg;
        empty_idx_next      = empty_idx_reg;
        parent_address_next = parent_address_reg;
        parent_held_next    = parent_held_reg;
        own_rank_next       = own_rank_reg;
        parent_age_next     = parent_age_reg;
        res_beacon_next     = res_beacon_reg;
        res_rank_next       = res_rank_reg;
        res_parent_next     = res_parent_reg;
        res_pvalid_next     = res_pvalid_reg;
        res_changed_next    = res_changed_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        send_beacon_next    = send_beacon_reg;
        rank_out_next       = rank_out_reg;
        parent_out_next     = parent_out_reg;
        parent_valid_next   = parent_valid_reg;
        parent_changed_next = parent_changed_reg;
        child_dropped_next  = child_dropped_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next        = func_t'(func);
                    from_next        = from_addr;
                    cnt_next         = '0;
                    match_found_next = 1'b0;
                    match_idx_next   = '0;
                    empty_found_next = 1'b0;
                    empty_idx_next   = '0;
                    res_beacon_next  = 1'b0;
                    res_changed_next = 1'b0;
                    res_rank_next    = own_rank_reg;
                    res_parent_next  = parent_address_reg;
                    res_pvalid_next  = parent_held_reg;
                    state_next       = S_SCAN;
                    case (func_t'(func))
                        FUNC_TICK:
                        begin
                            parent_age_next = age_up(parent_age_reg, timeout_reg);
                        end
                        FUNC_ADVERT:
                        begin
                            state_next = S_DONE;
                            if (adv_sum < {1'b0, own_rank_reg})
                            begin
                                parent_held_next    = 1'b1;
                                parent_address_next = from_addr;
                                own_rank_next       = adv_sum[RANK_W-1:0];
                                parent_age_next     = '0;
                                res_changed_next    = 1'b1;
                                res_rank_next       = adv_sum[RANK_W-1:0];
                                res_parent_next     = from_addr;
                                res_pvalid_next     = 1'b1;
                            end
                            else if (parent_held_reg && parent_address_reg == from_addr)
                            begin
                                parent_age_next = '0;
                            end
                        end
                        FUNC_BEACON:
                        begin
                            res_beacon_next = parent_held_reg;
                            if (expired(parent_age_reg, timeout_reg))
                            begin
                                parent_held_next    = 1'b0;
                                parent_address_next = '0;
                                own_rank_next       = NO_ROUTE;
                                res_pvalid_next     = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (func_reg == FUNC_KEEP)
                begin
                    if (!match_found_reg && head.addr == from_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = cnt_reg;
                    end
                    if (!empty_found_reg && head.addr == '0)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = cnt_reg;
                    end
                end
                cnt_next = cnt_reg + IDX_W'(1);
                if (last_slot)
                begin
                    cnt_next   = '0;
                    state_next = (func_reg == FUNC_KEEP) ? S_APPLY : S_DONE;
                end
            end
            S_APPLY:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (last_slot)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    send_beacon_next    = res_beacon_reg;
                    rank_out_next       = res_rank_reg;
                    parent_out_next     = res_parent_reg;
                    parent_valid_next   = res_pvalid_reg;
                    parent_changed_next = res_changed_reg;
                    child_dropped_next  = (func_reg == FUNC_KEEP)
                                          && !match_found_reg && !empty_found_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            func_reg           <= FUNC_TICK;
            cnt_reg            <= '0;
            match_found_reg    <= 1'b0;
            empty_found_reg    <= 1'b0;
            timeout_reg        <= TIMEOUT_RESET;
            parent_address_reg <= '0;
            parent_held_reg    <= 1'b0;
            own_rank_reg       <= NO_ROUTE;
            parent_age_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            func_reg           <= func_next;
            cnt_reg            <= cnt_next;
            match_found_reg    <= match_found_next;
            empty_found_reg    <= empty_found_next;
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            parent_address_reg <= parent_address_next;
            parent_held_reg    <= parent_held_next;
            own_rank_reg       <= own_rank_next;
            parent_age_reg     <= parent_age_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        from_reg           <= from_next;
        match_idx_reg      <= match_idx_next;
        empty_idx_reg      <= empty_idx_next;
        res_beacon_reg     <= res_beacon_next;
        res_rank_reg       <= res_rank_next;
        res_parent_reg     <= res_parent_next;
        res_pvalid_reg     <= res_pvalid_next;
        res_changed_reg    <= res_changed_next;
        send_beacon_reg    <= send_beacon_next;
        rank_out_reg       <= rank_out_next;
        parent_out_reg     <= parent_out_next;
        parent_valid_reg   <= parent_valid_next;
        parent_changed_reg <= parent_changed_next;
        child_dropped_reg  <= child_dropped_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign send_beacon    = send_beacon_reg;
    assign rank_out       = rank_out_reg;
    assign parent_out     = parent_out_reg;
    assign parent_valid   = parent_valid_reg;
    assign parent_changed = parent_changed_reg;
    assign child_dropped  = child_dropped_reg;

endmodule

// ===== design/tpct_cell.sv =====
// one child slot of the rotating slot ring: address and age
// depends on tpct_pkg
module tpct_cell
    import tpct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift_en,
    input  slot_t slot_in,
    output slot_t slot_out
);

    slot_t slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (shift_en)
        begin
            slot_reg <= slot_in;
        end
    end

    assign slot_out = slot_reg;

endmodule

// ===== tb/tree_parent_and_child_table_test.sv =====
// testbench for tree_parent_and_child_table: directed and random words, each result
// checked against a local model of the parent, rank and child slot state
// depends on tpct_pkg and the tree_parent_and_child_table rtl
module tree_parent_and_child_table_test;
    import tpct_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int POOL_SIZE = 14;

    typedef struct packed {
        logic              beacon;
        logic [RANK_W-1:0] rank;
        logic [ADDR_W-1:0] parent;
        logic              held;
        logic              changed;
        logic              dropped;
    } node_report_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [AGE_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        func;
    logic [ADDR_W-1:0] from_addr;
    logic [RANK_W-1:0] adv_rank;
    logic              out_valid;
    logic              out_ready;
    logic              send_beacon;
    logic [RANK_W-1:0] rank_out;
    logic [ADDR_W-1:0] parent_out;
    logic              parent_valid;
    logic              parent_changed;
    logic              child_dropped;

    // local copy of the node state
    logic [AGE_W-1:0]  node_timeout = TIMEOUT_RESET;
    logic [ADDR_W-1:0] node_parent = '0;
    logic              node_held = 1'b0;
    logic [RANK_W-1:0] node_rank = NO_ROUTE;
    logic [AGE_W-1:0]  node_parent_age = '0;
    logic [ADDR_W-1:0] slot_addr [CHILD_SLOTS];
    logic [AGE_W-1:0]  slot_age [CHILD_SLOTS];

    node_report_t      due_reports [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    int                idle_pct = 0;
    int                mismatches = 0;

    tree_parent_and_child_table u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .from_addr      (from_addr),
        .adv_rank       (adv_rank),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .send_beacon    (send_beacon),
        .rank_out       (rank_out),
        .parent_out     (parent_out),
        .parent_valid   (parent_valid),
        .parent_changed (parent_changed),
        .child_dropped  (child_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < CHILD_SLOTS; i++)
        begin
            slot_addr[i] = '0;
            slot_age[i] = '0;
        end
    end

    function automatic node_report_t compute_report(input func_t f,
                                                    input logic [ADDR_W-1:0] a,
                                                    input logic [RANK_W-1:0] r);
        node_report_t rep;
        int hit;
        rep = '0;
        hit = -1;
        case (f)
            FUNC_TICK:
            begin
                if (node_parent_age < node_timeout)
                    node_parent_age = node_parent_age + 1'b1;
                for (int i = 0; i < CHILD_SLOTS; i++)
                    if (slot_age[i] < node_timeout)
                        slot_age[i] = slot_age[i] + 1'b1;
            end
            FUNC_ADVERT:
            begin
                if ({1'b0, r} + 9'd1 < {1'b0, node_rank})
                begin
                    node_held = 1'b1;
                    node_parent = a;
                    node_rank = r + 1'b1;
                    node_parent_age = '0;
                    rep.changed = 1'b1;
                end
                else if (node_held && node_parent == a)
                    node_parent_age = '0;
            end
            FUNC_KEEP:
            begin
                for (int i = 0; i < CHILD_SLOTS; i++)
                    if (hit < 0 && slot_addr[i] == a)
                        hit = i;
                if (hit < 0)
                begin
                    for (int i = 0; i < CHILD_SLOTS; i++)
                        if (hit < 0 && slot_addr[i] == '0)
                            hit = i;
                    if (hit >= 0)
                        slot_addr[hit] = a;
                end
                if (hit >= 0)
                    slot_age[hit] = '0;
                else
                    rep.dropped = 1'b1;
            end
            default: ;
        endcase
        rep.rank = node_rank;
        rep.parent = node_parent;
        if (f == FUNC_BEACON)
        begin
            rep.beacon = node_held;
            if (node_parent_age >= node_timeout)
            begin
                node_held = 1'b0;
                node_parent = '0;
                node_rank = NO_ROUTE;
            end
            for (int i = 0; i < CHILD_SLOTS; i++)
                if (slot_age[i] >= node_timeout)
                    slot_addr[i] = '0;
        end
        rep.held = node_held;
        return rep;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 19) == 0)
            return ADDR_W'($urandom);
        return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // returns at the rising edge where the word is taken
    task automatic send_word(input func_t f, input logic [ADDR_W-1:0] a,
                             input logic [RANK_W-1:0] r);
        @(negedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid = 1'b1;
        func = f;
        from_addr = a;
        adv_rank = r;
        do
            @(posedge clk);
        while (!in_ready);
        due_reports.push_back(compute_report(f, a, r));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (due_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_timeout(input logic [AGE_W-1:0] v);
        drain();
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        node_timeout = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic test_reset_state();
        send_word(FUNC_BEACON, 16'h0000, 8'h00);
        send_word(FUNC_KEEP, 16'h0000, 8'hFF);
    endtask

    task automatic test_parent_selection();
        send_word(FUNC_ADVERT, 16'h1234, 8'd255);
        send_word(FUNC_ADVERT, 16'h0000, 8'd253);
        send_word(FUNC_ADVERT, 16'h0000, 8'd200);
        send_word(FUNC_ADVERT, 16'hFFFF, 8'd0);
        send_word(FUNC_ADVERT, 16'h5A5A, 8'd0);
    endtask

    task automatic test_child_slots();
        for (int i = 0; i < CHILD_SLOTS; i++)
            send_word(FUNC_KEEP, 16'h8000 | ADDR_W'(i * 16'h0111 + 1), 8'h00);
        send_word(FUNC_KEEP, 16'h7FFF, 8'h00);
        send_word(FUNC_KEEP, 16'h0000, 8'h00);
    endtask

    task automatic test_expiry();
        write_timeout(8'd2);
        repeat (3) send_word(FUNC_TICK, 16'h0000, 8'h00);
        send_word(FUNC_BEACON, 16'hFFFF, 8'hFF);
        // zero timeout: nothing ages, everything is expired
        write_timeout(8'd0);
        send_word(FUNC_TICK, 16'h0000, 8'h00);
        send_word(FUNC_ADVERT, 16'h0007, 8'd5);
        send_word(FUNC_BEACON, 16'h0000, 8'h00);
        // raise the timeout, let ages grow, then lower it below ages already reached
        write_timeout(8'd255);
        send_word(FUNC_ADVERT, 16'h0003, 8'd9);
        send_word(FUNC_KEEP, 16'h00C3, 8'h00);
        repeat (3) send_word(FUNC_TICK, 16'h0000, 8'h00);
        write_timeout(8'd1);
        send_word(FUNC_TICK, 16'h0000, 8'h00);
        send_word(FUNC_BEACON, 16'h0000, 8'h00);
    endtask

    task automatic test_random_traffic();
        logic [AGE_W-1:0]  timeouts [8];
        logic [ADDR_W-1:0] a;
        logic [RANK_W-1:0] r;
        int sel;
        timeouts = '{8'd1, 8'd3, 8'd255, 8'd0, 8'd2, 8'd45, 8'd6, 8'd12};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_timeout(timeouts[ph]);
            addr_pool[0] = 16'h0000;
            addr_pool[1] = 16'hFFFF;
            for (int i = 2; i < POOL_SIZE; i++)
                addr_pool[i] = ADDR_W'($urandom);
            for (int n = 0; n < 165; n++)
            begin
                if (ph == 7)
                    idle_pct = 0;
                else if (n % 40 == 0)
                    idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
                sel = $urandom_range(0, 99);
                if (sel < 35)
                    send_word(FUNC_TICK, ADDR_W'($urandom), RANK_W'($urandom));
                else if (sel < 55)
                begin
                    a = ($urandom_range(0, 99) < 40) ? node_parent : pick_addr();
                    sel = $urandom_range(0, 99);
                    if (sel < 35 || node_rank < 2)
                        r = RANK_W'($urandom);
                    else
                        r = node_rank - RANK_W'($urandom_range(1, 2));
                    send_word(FUNC_ADVERT, a, r);
                end
                else if (sel < 85)
                    send_word(FUNC_KEEP, pick_addr(), RANK_W'($urandom));
                else
                    send_word(FUNC_BEACON, ADDR_W'($urandom), RANK_W'($urandom));
            end
        end
    endtask

    initial
    begin : result_sink
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < idle_pct)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        node_report_t want;
        if (out_valid && out_ready)
        begin
            if (due_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: rank=%0d parent=%h",
                             rank_out, parent_out);
            end
            else
            begin
                want = due_reports.pop_front();
                if (send_beacon !== want.beacon || rank_out !== want.rank
                    || parent_out !== want.parent || parent_valid !== want.held
                    || parent_changed !== want.changed || child_dropped !== want.dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected beacon=%0d rank=%0d parent=%h ",
                                  "valid=%0d changed=%0d dropped=%0d, got beacon=%0d ",
                                  "rank=%0d parent=%h valid=%0d changed=%0d dropped=%0d"},
                                 want.beacon, want.rank, want.parent, want.held,
                                 want.changed, want.dropped, send_beacon, rank_out,
                                 parent_out, parent_valid, parent_changed, child_dropped);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("tree_parent_and_child_table_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        in_valid = 1'b0;
        func = FUNC_TICK;
        from_addr = '0;
        adv_rank = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_reset_state();
        test_parent_selection();
        test_child_slots();
        test_expiry();
        test_random_traffic();
        drain();
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("tree_parent_and_child_table_test OK");
        else
            $display("tree_parent_and_child_table_test NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tpct_pkg.sv
design/tpct_cell.sv
design/tree_parent_and_child_table.sv
tb/tree_parent_and_child_table_test.sv
